@@ design/tlrq_pkg.sv @@
// ----------------------------------------------------------------------------
// Three-level ready queue scheduler: shared definitions
// Transaction payload types, field widths, codes and reset values used by the
// scheduler top level and its queue chains.
// ----------------------------------------------------------------------------
package tlrq_pkg;

   localparam int ID_W    = 8;
   localparam int PRIO_W  = 8;
   localparam int BURST_W = 20;
   localparam int LEVEL_W = 2;
   localparam int STATUS_W = 2;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 8;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   // Request kinds.
   localparam logic KIND_INSERT   = 1'b0;
   localparam logic KIND_DISPATCH = 1'b1;

   // Queue levels reported in a response.
   localparam logic [LEVEL_W-1:0] LEVEL_NONE  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_THREE = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_ONE_MIN = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_TWO_MIN = 1'd1;

   localparam logic [PRIO_W-1:0] LEVEL_ONE_MIN_RESET = 8'd100;
   localparam logic [PRIO_W-1:0] LEVEL_TWO_MIN_RESET = 8'd50;

   typedef struct packed {
      logic               kind;
      logic [ID_W-1:0]    thread_id;
      logic [PRIO_W-1:0]  priority_req;
      logic [BURST_W-1:0] burst_estimate;
      logic [BURST_W-1:0] time_used;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]     selected_id;
      logic [LEVEL_W-1:0]  level;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Operation applied to one queue chain in a cycle.
   typedef struct packed {
      logic ins;
      logic pop;
   } chain_op_type;

   // Occupancy reported by one queue chain.
   typedef struct packed {
      logic empty;
      logic full;
   } chain_status_type;

endpackage

@@ design/three_level_ready_queue_scheduler.sv @@
// ----------------------------------------------------------------------------
// Three-level ready queue scheduler
// Keeps three ready queues of thread ids: level one sorted by remaining burst,
// level two sorted by descending priority, level three in arrival order.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction on req_* either inserts a ready thread (kind insert)
// or dispatches the next thread (kind dispatch). Every request transaction
// yields exactly one response transaction on rsp_*, in request order.
// The request is captured in an operation register at acceptance and applied
// to the three queue chains, loading the response register, once that register
// can take a result. While it executes, the next request can already be
// accepted, so the block sustains one transaction per cycle when the receiver
// does not stall. When rsp_stall holds a waiting response, the captured
// operation stays pending and req_stall is raised until the response register
// frees up. The csr_* port sets the two priority thresholds; the user must
// write it only while idle; the block does not enforce this. A synchronous
// reset empties all queues, drops any pending transaction and restores the
// thresholds to 100 and 50; queue slot contents are not cleared.
// ----------------------------------------------------------------------------
module three_level_ready_queue_scheduler
   import tlrq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Thresholds.
   logic [PRIO_W-1:0] l1_min_ff, l1_min_in;
   logic [PRIO_W-1:0] l2_min_ff, l2_min_in;

   // Captured operation: level and sort keys are resolved at acceptance.
   logic               op_valid_ff, op_valid_in;
   logic               op_kind_ff;
   logic [ID_W-1:0]    op_id_ff;
   logic [LEVEL_W-1:0] op_level_ff;
   logic [BURST_W-1:0] op_rem_ff;
   logic [PRIO_W-1:0]  op_prio_key_ff;

   logic               req_accept;
   logic [LEVEL_W-1:0] req_level;
   logic [BURST_W-1:0] req_rem;

   // Response register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic execute;

   chain_op_type     l1_op, l2_op, l3_op;
   chain_status_type l1_status, l2_status, l3_status;
   logic [ID_W-1:0]  l1_head, l2_head, l3_head;

   // The operation register executes once the response register can take
   // its result, and a new request may enter in that same cycle.
   assign execute    = op_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = op_valid_ff && !execute;
   assign req_accept = req_valid && !req_stall;

   // Level one is tested first, so a level-two threshold above the level-one
   // threshold leaves level two unreachable.
   always_comb begin
      if (req_data.priority_req >= l1_min_ff) begin
         req_level = LEVEL_ONE;
      end else if (req_data.priority_req >= l2_min_ff) begin
         req_level = LEVEL_TWO;
      end else begin
         req_level = LEVEL_THREE;
      end
   end

   // Remaining burst, clipped at zero.
   assign req_rem = (req_data.burst_estimate > req_data.time_used) ?
                    (req_data.burst_estimate - req_data.time_used) : '0;

   always_comb begin
      op_valid_in = op_valid_ff;
      if (req_accept) begin
         op_valid_in = 1'b1;
      end else if (execute) begin
         op_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff <= 1'b0;
      end else begin
         op_valid_ff <= op_valid_in;
      end
   end

   // Level two sorts by descending priority; the inverted priority turns
   // that into the same ascending order the chain keeps.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_kind_ff     <= req_data.kind;
         op_id_ff       <= req_data.thread_id;
         op_level_ff    <= req_level;
         op_rem_ff      <= req_rem;
         op_prio_key_ff <= ~req_data.priority_req;
      end
   end

   // Queue selection and response formation.
   always_comb begin
      l1_op       = '0;
      l2_op       = '0;
      l3_op       = '0;
      rsp_data_in = rsp_data_ff;
      if (execute) begin
         if (op_kind_ff == KIND_INSERT) begin
            rsp_data_in.selected_id = op_id_ff;
            rsp_data_in.level       = op_level_ff;
            rsp_data_in.status      = STATUS_OK;
            unique case (op_level_ff)
               LEVEL_ONE: begin
                  if (l1_status.full) begin
                     rsp_data_in.status = STATUS_FULL;
                  end else begin
                     l1_op.ins = 1'b1;
                  end
               end
               LEVEL_TWO: begin
                  if (l2_status.full) begin
                     rsp_data_in.status = STATUS_FULL;
                  end else begin
                     l2_op.ins = 1'b1;
                  end
               end
               default: begin
                  if (l3_status.full) begin
                     rsp_data_in.status = STATUS_FULL;
                  end else begin
                     l3_op.ins = 1'b1;
                  end
               end
            endcase
         end else begin
            rsp_data_in.status = STATUS_OK;
            if (!l1_status.empty) begin
               l1_op.pop               = 1'b1;
               rsp_data_in.selected_id = l1_head;
               rsp_data_in.level       = LEVEL_ONE;
            end else if (!l2_status.empty) begin
               l2_op.pop               = 1'b1;
               rsp_data_in.selected_id = l2_head;
               rsp_data_in.level       = LEVEL_TWO;
            end else if (!l3_status.empty) begin
               l3_op.pop               = 1'b1;
               rsp_data_in.selected_id = l3_head;
               rsp_data_in.level       = LEVEL_THREE;
            end else begin
               rsp_data_in.selected_id = '0;
               rsp_data_in.level       = LEVEL_NONE;
               rsp_data_in.status      = STATUS_EMPTY;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (execute) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Threshold registers.
   always_comb begin
      l1_min_in = l1_min_ff;
      l2_min_in = l2_min_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_LEVEL_ONE_MIN: l1_min_in = csr_wdata;
            CSR_LEVEL_TWO_MIN: l2_min_in = csr_wdata;
            default: begin
               l1_min_in = l1_min_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_min_ff <= LEVEL_ONE_MIN_RESET;
         l2_min_ff <= LEVEL_TWO_MIN_RESET;
      end else begin
         l1_min_ff <= l1_min_in;
         l2_min_ff <= l2_min_in;
      end
   end

   // Level one: sorted by remaining burst, then id.
   tlrq_chain #(
      .DEPTH (QUEUE_DEPTH),
      .KEY_W (BURST_W)
   ) u_level_one (
      .clock    (clock),
      .reset    (reset),
      .op       (l1_op),
      .order_en (1'b1),
      .new_key  (op_rem_ff),
      .new_id   (op_id_ff),
      .head_id  (l1_head),
      .status   (l1_status)
   );

   // Level two: sorted by inverted priority, then id.
   tlrq_chain #(
      .DEPTH (QUEUE_DEPTH),
      .KEY_W (PRIO_W)
   ) u_level_two (
      .clock    (clock),
      .reset    (reset),
      .op       (l2_op),
      .order_en (1'b1),
      .new_key  (op_prio_key_ff),
      .new_id   (op_id_ff),
      .head_id  (l2_head),
      .status   (l2_status)
   );

   // Level three: arrival order, the key is not used.
   tlrq_chain #(
      .DEPTH (QUEUE_DEPTH),
      .KEY_W (1)
   ) u_level_three (
      .clock    (clock),
      .reset    (reset),
      .op       (l3_op),
      .order_en (1'b0),
      .new_key  (1'b0),
      .new_id   (op_id_ff),
      .head_id  (l3_head),
      .status   (l3_status)
   );

endmodule

@@ design/tlrq_cell.sv @@
// ----------------------------------------------------------------------------
// Queue cell
// One slot of a queue chain. It holds a key and a thread id, decides whether
// a new entry belongs at or ahead of it, and takes its neighbor's entry when
// the chain shifts.
// ----------------------------------------------------------------------------
module tlrq_cell
   import tlrq_pkg::*;
#(
   parameter int KEY_W = BURST_W
) (
   input  logic             clock,
   input  chain_op_type     op,
   input  logic             order_en,
   input  logic             occupied,
   input  logic             prev_shift,
   input  logic [KEY_W-1:0] new_key,
   input  logic [ID_W-1:0]  new_id,
   input  logic [KEY_W-1:0] left_key,
   input  logic [ID_W-1:0]  left_id,
   input  logic [KEY_W-1:0] right_key,
   input  logic [ID_W-1:0]  right_id,
   output logic [KEY_W-1:0] key,
   output logic [ID_W-1:0]  id,
   output logic             shift
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic             after_new;

   // The held entry sorts after the new one; equal key and id also yield.
   assign after_new = order_en &&
                      ((key_ff > new_key) || ((key_ff == new_key) && (id_ff >= new_id)));
   assign shift = !occupied || after_new;

   always_comb begin
      key_in = key_ff;
      id_in  = id_ff;
      if (op.ins && shift) begin
         if (prev_shift) begin
            key_in = left_key;
            id_in  = left_id;
         end else begin
            key_in = new_key;
            id_in  = new_id;
         end
      end else if (op.pop) begin
         key_in = right_key;
         id_in  = right_id;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      id_ff  <= id_in;
   end

   assign key = key_ff;
   assign id  = id_ff;

endmodule

@@ design/tlrq_chain.sv @@
// ----------------------------------------------------------------------------
// Queue chain
// A row of queue cells with a fill count. With ordering enabled it keeps
// entries sorted by ascending key, then ascending id; without it, it is FIFO.
// ----------------------------------------------------------------------------
module tlrq_chain
   import tlrq_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int KEY_W = BURST_W
) (
   input  logic             clock,
   input  logic             reset,
   input  chain_op_type     op,
   input  logic             order_en,
   input  logic [KEY_W-1:0] new_key,
   input  logic [ID_W-1:0]  new_id,
   output logic [ID_W-1:0]  head_id,
   output chain_status_type status
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [KEY_W-1:0] cell_key   [DEPTH];
   logic [ID_W-1:0]  cell_id    [DEPTH];
   logic             cell_shift [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_W-1:0] left_key, right_key;
      logic [ID_W-1:0]  left_id, right_id;
      logic             prev_shift;

      if (i == 0) begin : g_first
         assign left_key   = new_key;
         assign left_id    = new_id;
         assign prev_shift = 1'b0;
      end else begin : g_inner_left
         assign left_key   = cell_key[i-1];
         assign left_id    = cell_id[i-1];
         assign prev_shift = cell_shift[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_key = cell_key[i];
         assign right_id  = cell_id[i];
      end else begin : g_inner_right
         assign right_key = cell_key[i+1];
         assign right_id  = cell_id[i+1];
      end

      tlrq_cell #(
         .KEY_W(KEY_W)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .order_en   (order_en),
         .occupied   (count_ff > CNT_W'(i)),
         .prev_shift (prev_shift),
         .new_key    (new_key),
         .new_id     (new_id),
         .left_key   (left_key),
         .left_id    (left_id),
         .right_key  (right_key),
         .right_id   (right_id),
         .key        (cell_key[i]),
         .id         (cell_id[i]),
         .shift      (cell_shift[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (op.ins) begin
         count_in = count_ff + CNT_ONE;
      end else if (op.pop) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head_id      = cell_id[0];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_FULL);

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Three-level ready queue scheduler testbench
// Drives insert and dispatch transactions through the request channel and
// checks every response against a cycle-free model of the three ready queues
// kept inside this module. A short directed table comes first, followed by
// randomized phases under several threshold settings, with bursty requests,
// random response stalls and one long response hold-off.
// ----------------------------------------------------------------------------
module tb;
   import tlrq_pkg::*;

   // The block is built with its default depth, and the model below tracks
   // the same depth.
   localparam int QDEPTH           = QUEUE_DEPTH_DEFAULT;
   localparam int RANDOM_PHASES    = 7;
   localparam int ITEMS_PER_PHASE  = 185;
   localparam int PRESSURE_ITEMS   = 40;
   localparam int LONG_HOLD_CYCLES = 150;
   // Longest quiet stretch in a correct run is the long hold-off; the
   // limit is many times that.
   localparam int QUIET_LIMIT      = 4000;
   localparam int MAX_PRINTED      = 100;

   typedef struct {
      req_type item;
      int      reps;
      bit      pinned;
      rsp_type pinned_rsp;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // A directed row may carry a response typed in by hand; it travels with
   // the request so the monitor can queue it at acceptance.
   logic    row_pinned;
   rsp_type row_pinned_rsp;

   // Model of the scheduler: thresholds, the two sorted queues and the
   // circular arrival-order queue.
   logic [PRIO_W-1:0]  thr_one;
   logic [PRIO_W-1:0]  thr_two;
   logic [BURST_W-1:0] l1_rem  [QDEPTH];
   logic [ID_W-1:0]    l1_id   [QDEPTH];
   logic [PRIO_W-1:0]  l2_prio [QDEPTH];
   logic [ID_W-1:0]    l2_id   [QDEPTH];
   logic [ID_W-1:0]    l3_id   [QDEPTH];
   int                 l1_cnt;
   int                 l2_cnt;
   int                 l3_cnt;
   int                 l3_head;

   rsp_type awaited_rsp [$];
   int      fail_count;
   int      quiet_cycles;
   int      burst_left;
   bit      long_hold_req;

   logic [PRIO_W-1:0] plan_one [RANDOM_PHASES] = '{8'd100, 8'd255, 8'd0, 8'd128,
                                                   8'd255, 8'd60, 8'd0};
   logic [PRIO_W-1:0] plan_two [RANDOM_PHASES] = '{8'd50, 8'd0, 8'd0, 8'd200,
                                                   8'd255, 8'd59, 8'd0};

   three_level_ready_queue_scheduler u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Applies one request transaction to the model and returns the response
   // the block owes for it.
   function automatic rsp_type scheduler_step(req_type r);
      logic [BURST_W-1:0] left;
      int                 pos;
      int                 i;
      rsp_type            res;
      res.selected_id = r.thread_id;
      res.status      = STATUS_OK;
      if (r.kind == KIND_DISPATCH) begin
         if (l1_cnt > 0) begin
            res.selected_id = l1_id[0];
            res.level       = LEVEL_ONE;
            for (i = 1; i < l1_cnt; i++) begin
               l1_rem[i-1] = l1_rem[i];
               l1_id[i-1]  = l1_id[i];
            end
            l1_cnt--;
         end else if (l2_cnt > 0) begin
            res.selected_id = l2_id[0];
            res.level       = LEVEL_TWO;
            for (i = 1; i < l2_cnt; i++) begin
               l2_prio[i-1] = l2_prio[i];
               l2_id[i-1]   = l2_id[i];
            end
            l2_cnt--;
         end else if (l3_cnt > 0) begin
            res.selected_id = l3_id[l3_head];
            res.level       = LEVEL_THREE;
            l3_head         = (l3_head + 1) % QDEPTH;
            l3_cnt--;
         end else begin
            res.selected_id = '0;
            res.level       = LEVEL_NONE;
            res.status      = STATUS_EMPTY;
         end
      end else if (r.priority_req >= thr_one) begin
         // Remaining burst is fixed here and clipped at zero.
         left      = (r.burst_estimate > r.time_used) ? r.burst_estimate - r.time_used : '0;
         res.level = LEVEL_ONE;
         if (l1_cnt >= QDEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < l1_cnt && !(l1_rem[pos] > left ||
                   (l1_rem[pos] == left && l1_id[pos] >= r.thread_id)))
               pos++;
            for (i = l1_cnt; i > pos; i--) begin
               l1_rem[i] = l1_rem[i-1];
               l1_id[i]  = l1_id[i-1];
            end
            l1_rem[pos] = left;
            l1_id[pos]  = r.thread_id;
            l1_cnt++;
         end
      end else if (r.priority_req >= thr_two) begin
         res.level = LEVEL_TWO;
         if (l2_cnt >= QDEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < l2_cnt && !(l2_prio[pos] < r.priority_req ||
                   (l2_prio[pos] == r.priority_req && l2_id[pos] >= r.thread_id)))
               pos++;
            for (i = l2_cnt; i > pos; i--) begin
               l2_prio[i] = l2_prio[i-1];
               l2_id[i]   = l2_id[i-1];
            end
            l2_prio[pos] = r.priority_req;
            l2_id[pos]   = r.thread_id;
            l2_cnt++;
         end
      end else begin
         res.level = LEVEL_THREE;
         if (l3_cnt >= QDEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            l3_id[(l3_head + l3_cnt) % QDEPTH] = r.thread_id;
            l3_cnt++;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (fail_count < MAX_PRINTED)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // Both channels are observed at the rising edge, before the block's
   // registers move. Responses are checked first; a request accepted on the
   // same edge cannot be the source of a response on that edge.
   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type predicted;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            if (awaited_rsp.size() == 0) begin
               report_mismatch("response with nothing awaited",
                               32'(rsp_data.selected_id), 32'd0);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.selected_id !== want.selected_id)
                  report_mismatch("selected_id", 32'(rsp_data.selected_id),
                                  32'(want.selected_id));
               if (rsp_data.level !== want.level)
                  report_mismatch("level", 32'(rsp_data.level), 32'(want.level));
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            end
         end
         if (req_valid && !req_stall) begin
            quiet_cycles = 0;
            predicted    = scheduler_step(req_data);
            awaited_rsp.push_back(row_pinned ? row_pinned_rsp : predicted);
         end
      end
   end

   // The watchdog ends a run in which no transaction moves for too long.
   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // The response side stalls in segments of random length, each with its own
   // stall rate, one of which never stalls. When asked, it holds off for a long
   // stretch so that the block fills up and pushes back on requests.
   initial begin : rsp_side
      int seg_len;
      int pct;
      rsp_stall = 1'b0;
      forever begin
         seg_len = $urandom_range(40, 5);
         case ($urandom_range(3))
            0:       pct = 0;
            1:       pct = 25;
            2:       pct = 60;
            default: pct = 90;
         endcase
         repeat (seg_len) begin
            @(negedge clock);
            if (long_hold_req) begin
               rsp_stall <= 1'b1;
               repeat (LONG_HOLD_CYCLES) @(negedge clock);
               long_hold_req = 1'b0;
            end
            rsp_stall <= ($urandom_range(99) < pct);
         end
      end
   end

   // Presents one request transaction at a falling edge and returns once the
   // block has taken it. Valid stays high afterwards unless pacing drops it.
   task automatic offer(req_type item, bit pinned, rsp_type pinned_rsp);
      @(negedge clock);
      req_valid      <= 1'b1;
      req_data       <= item;
      row_pinned     <= pinned;
      row_pinned_rsp <= pinned_rsp;
      do @(posedge clock); while (req_stall);
   endtask

   // Requests go out in bursts; between most bursts valid drops for a random
   // gap, and some bursts run long without any gap.
   task automatic pace();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(8, 1);
         if (gap > 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
      end
   endtask

   // Drops valid, then waits until every owed response has come back.
   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes both thresholds on consecutive cycles while the block is idle.
   task automatic set_thresholds(logic [PRIO_W-1:0] one_min, logic [PRIO_W-1:0] two_min);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_LEVEL_ONE_MIN;
      csr_wdata <= one_min;
      @(negedge clock);
      csr_addr  <= CSR_LEVEL_TWO_MIN;
      csr_wdata <= two_min;
      @(negedge clock);
      csr_we    <= 1'b0;
      thr_one = one_min;
      thr_two = two_min;
   endtask

   function automatic stim_row_type ins_row(logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                                            logic [BURST_W-1:0] burst,
                                            logic [BURST_W-1:0] used, int reps);
      stim_row_type r;
      r.item       = '{KIND_INSERT, id, prio, burst, used};
      r.reps       = reps;
      r.pinned     = 1'b0;
      r.pinned_rsp = '0;
      return r;
   endfunction

   // Dispatch rows carry filler patterns in the fields the block ignores.
   function automatic stim_row_type disp_row(int reps);
      stim_row_type r;
      r.item       = '{KIND_DISPATCH, 8'hA5, 8'h5A, 20'hAAAAA, 20'h55555};
      r.reps       = reps;
      r.pinned     = 1'b0;
      r.pinned_rsp = '0;
      return r;
   endfunction

   function automatic stim_row_type pin(stim_row_type r, logic [ID_W-1:0] id,
                                        logic [LEVEL_W-1:0] lvl, logic [STATUS_W-1:0] st);
      stim_row_type p;
      p            = r;
      p.pinned     = 1'b1;
      p.pinned_rsp = '{id, lvl, st};
      return p;
   endfunction

   // Random transaction: small ids and small bursts make ties common, and
   // priorities cluster around the current thresholds.
   function automatic req_type random_item(int insert_pct);
      req_type it;
      int      pick;
      it.kind      = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_DISPATCH;
      it.thread_id = $urandom_range(1) ? ID_W'($urandom) : ID_W'($urandom_range(7));
      pick = $urandom_range(9);
      if (pick < 4)
         it.priority_req = PRIO_W'($urandom);
      else if (pick < 8)
         it.priority_req = PRIO_W'((pick[0] ? thr_one : thr_two) + $urandom_range(2) - 1);
      else
         it.priority_req = pick[0] ? 8'hFF : 8'h00;
      it.burst_estimate = BURST_W'($urandom);
      it.time_used      = BURST_W'($urandom);
      pick = $urandom_range(9);
      if (pick < 3) begin
         it.burst_estimate = BURST_W'($urandom_range(15));
         it.time_used      = BURST_W'($urandom_range(15));
      end else if (pick < 5) begin
         it.time_used = it.burst_estimate;
      end else if (pick < 6) begin
         it.burst_estimate = '1;
         it.time_used      = '0;
      end
      return it;
   endfunction

   initial begin : stimulus
      stim_row_type      rows [$];
      stim_row_type      r;
      req_type           item;
      rsp_type           no_pin;
      logic [PRIO_W-1:0] t1;
      logic [PRIO_W-1:0] t2;
      int                ph;
      int                k;
      int                n;
      int                seg_left;
      int                insert_pct;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_we         = 1'b0;
      csr_addr       = '0;
      csr_wdata      = '0;
      row_pinned     = 1'b0;
      row_pinned_rsp = '0;
      no_pin         = '0;
      long_hold_req  = 1'b0;
      fail_count     = 0;
      quiet_cycles   = 0;
      burst_left     = 1;
      thr_one        = LEVEL_ONE_MIN_RESET;
      thr_two        = LEVEL_TWO_MIN_RESET;
      l1_cnt         = 0;
      l2_cnt         = 0;
      l3_cnt         = 0;
      l3_head        = 0;

      // Directed table, run under the reset thresholds of 100 and 50. Rows with
      // a typed-in response are the ones whose outcome is plain on sight.
      rows.push_back(pin(disp_row(1), 8'h00, LEVEL_NONE, STATUS_EMPTY));
      rows.push_back(pin(ins_row(8'hFF, 8'hFF, 20'hFFFFF, 20'h00000, 1),
                         8'hFF, LEVEL_ONE, STATUS_OK));
      // Exactly at the level one threshold; burst below used clips to zero.
      rows.push_back(pin(ins_row(8'h00, 8'd100, 20'h00005, 20'h00009, 1),
                         8'h00, LEVEL_ONE, STATUS_OK));
      rows.push_back(pin(ins_row(8'h10, 8'd99, 20'h12345, 20'h00001, 1),
                         8'h10, LEVEL_TWO, STATUS_OK));
      rows.push_back(pin(ins_row(8'h11, 8'd50, 20'h00000, 20'h00000, 1),
                         8'h11, LEVEL_TWO, STATUS_OK));
      rows.push_back(pin(ins_row(8'h12, 8'd49, 20'hFFFFF, 20'hFFFFF, 1),
                         8'h12, LEVEL_THREE, STATUS_OK));
      rows.push_back(pin(ins_row(8'h13, 8'd0, 20'h00000, 20'hFFFFF, 1),
                         8'h13, LEVEL_THREE, STATUS_OK));
      // Equal burst and used gives zero, tying with id zero on remaining burst.
      rows.push_back(ins_row(8'h05, 8'd120, 20'h00100, 20'h00100, 1));
      // Same remaining burst and same id as an entry already queued.
      rows.push_back(ins_row(8'h05, 8'd200, 20'h00000, 20'h00000, 1));
      rows.push_back(ins_row(8'h7F, 8'd150, 20'h80000, 20'h7FFFF, 1));
      // Priority tie in level two; the smaller id goes first.
      rows.push_back(ins_row(8'h08, 8'd99, 20'h0000F, 20'h00000, 1));
      rows.push_back(ins_row(8'h80, 8'd75, 20'h33333, 20'h11111, 1));
      rows.push_back(disp_row(11));
      rows.push_back(pin(disp_row(1), 8'h00, LEVEL_NONE, STATUS_EMPTY));
      // Fill level three so its circular head wraps, then overflow it.
      rows.push_back(ins_row(8'h40, 8'd1, 20'h0F0F0, 20'h0F0F0, QDEPTH));
      rows.push_back(pin(ins_row(8'hC3, 8'd49, 20'h00001, 20'h00002, 1),
                         8'hC3, LEVEL_THREE, STATUS_FULL));
      rows.push_back(ins_row(8'hE0, 8'd255, 20'h00010, 20'h00000, 3));
      rows.push_back(disp_row(QDEPTH + 3));
      rows.push_back(pin(disp_row(1), 8'h00, LEVEL_NONE, STATUS_EMPTY));

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         r = rows[i];
         for (k = 0; k < r.reps; k++) begin
            item           = r.item;
            item.thread_id = item.thread_id + ID_W'(k);
            offer(item, r.pinned, r.pinned_rsp);
            pace();
         end
      end

      // Random phases. Queue contents carry over from one phase to the next,
      // so entries placed under one threshold setting are dispatched under
      // another. The plan covers both extremes of each threshold, level two
      // above level one, and adjacent thresholds; the last phase is random.
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         t1 = plan_one[ph];
         t2 = plan_two[ph];
         if (ph == RANDOM_PHASES - 1) begin
            t1 = PRIO_W'($urandom);
            t2 = PRIO_W'($urandom);
         end
         set_thresholds(t1, t2);
         if (ph == 1) begin
            // Keep offering back to back while the response side holds off.
            long_hold_req = 1'b1;
            for (k = 0; k < PRESSURE_ITEMS; k++)
               offer(random_item(60), 1'b0, no_pin);
         end
         n = 0;
         while (n < ITEMS_PER_PHASE) begin
            // Segments lean toward filling or draining so that full and empty
            // queues both come up regularly.
            seg_left = $urandom_range(40, 10);
            case ($urandom_range(2))
               0:       insert_pct = 85;
               1:       insert_pct = 50;
               default: insert_pct = 15;
            endcase
            for (k = 0; k < seg_left && n < ITEMS_PER_PHASE; k++) begin
               offer(random_item(insert_pct), 1'b0, no_pin);
               pace();
               n++;
            end
         end
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (awaited_rsp.size() != 0)
         report_mismatch("responses never delivered", 32'(awaited_rsp.size()), 32'd0);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ filelist.f @@
design/tlrq_pkg.sv
design/tlrq_cell.sv
design/tlrq_chain.sv
design/three_level_ready_queue_scheduler.sv
tb/sv/tb.sv
